FILE: sv/rmvd_pkg.sv
// shared types and constants for the rssi moving variance detector
// no dependencies; imported by the divider and the top level

package rmvd_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 8;
  localparam int LEN_W    = 9;
  localparam int THR_W    = 16;
  localparam int DEV_W    = 16;
  localparam int SUM_W    = 24;
  localparam int LEVEL_W  = 25;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  // accumulator of up to 511 samples, and its magnitude
  localparam int ACC_W    = 18;
  localparam int MAG_W    = 17;
  localparam int DIFF_W   = 10;
  localparam int DCNT_W   = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_AVERAGE_LENGTH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTEGRATOR_LENGTH = 3'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD         = 3'd3;
  localparam logic [IDX_W-1:0] REG_SMOOTHING_ENABLE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_THRESHOLD_ENABLE  = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AVG,
    ST_DIV,
    ST_DEV,
    ST_SUM,
    ST_DONE
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/rmvd_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module rmvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rmvd_div.sv
// restoring divider, one quotient bit per cycle, unsigned
// depends on rmvd_pkg for widths and request/response types

module rmvd_div
  import rmvd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  dvs;
  logic [MAG_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [LEN_W:0]    shifted;
  logic [LEN_W:0]    trial;
  logic              fits;

  // one trial subtraction
  always_comb begin
    shifted = {rem, quo[MAG_W-1]};
    trial   = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(MAG_W);
        quo  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
        quo <= {quo[MAG_W-2:0], fits};
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: sv/rssi_moving_variance_detector_top.sv
// top level: control sequencer, config registers, sample and deviation rings
// depends on rmvd_pkg, rmvd_ram and rmvd_div
//
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   sample  (8 bit signed)
// out      output     out_valid / out_stall level   (25 bit signed)
// cfg      input      cfg_we                cfg_index, cfg_data
//
// while the sample ring fills an item skips the walks and the divider;
// afterwards the time per item is set by the walks over average_length samples
// and integrator_length deviations (one read port per ring) and the 17-step divider.
// after reset zeros are swept through the whole deviation ring, and no item is
// taken meanwhile. a new item is taken while a result waits on a stalled output;
// the next result waits until the output register is free.

module rssi_moving_variance_detector_top
  import rmvd_pkg::*;
#(
  parameter int MAX_WINDOW = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [LEVEL_W-1:0]  level,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int PW   = $clog2(MAX_WINDOW);
  localparam int WMAX = (MAX_WINDOW > 511) ? 511 : MAX_WINDOW;

  state_t state, state_next;

  // configuration registers
  logic [LEN_W-1:0] window_length;
  logic [LEN_W-1:0] average_length;
  logic [LEN_W-1:0] integrator_length;
  logic [THR_W-1:0] threshold;
  logic             smoothing_enable;
  logic             threshold_enable;

  // persistent state
  logic [PW-1:0]    sample_pos;
  logic             ring_filled;
  logic [PW-1:0]    deviation_pos;
  logic [SUM_W-1:0] smoothed_sum;
  logic [PW-1:0]    clr_idx;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] s_reg;
  logic                       filling;
  logic [PW-1:0]              idx;
  logic [LEN_W-1:0]           cnt;
  logic                       rd_pend;
  logic signed [ACC_W-1:0]    acc;
  logic signed [DIFF_W-1:0]   avg;
  logic [SUM_W-1:0]           sum;

  // combinational helpers
  logic [LEN_W-1:0]         w, na, ni, walk_len;
  logic [PW-1:0]            s_cur, s_pos_next, d_cur, d_pos_next, dec_idx;
  logic                     s_wrap, filled_next;
  logic                     in_acc, out_free, issue, walk_done;
  logic [SAMPLE_W-1:0]      s_rdata;
  logic [DEV_W-1:0]         d_rdata;
  logic                     d_we;
  logic [PW-1:0]            d_waddr;
  logic [DEV_W-1:0]         d_wdata;
  logic signed [DIFF_W-1:0] diff;
  logic [SAMPLE_W-1:0]      mag;
  logic [DEV_W-1:0]         sq;
  logic [SUM_W:0]           sum_add;
  logic [SUM_W:0]           smooth_add;
  logic [SUM_W-1:0]         smooth_new;
  logic [SUM_W-1:0]         lvl;
  logic [MAG_W-1:0]         acc_mag;
  logic [DIFF_W-1:0]        q_ext;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // length clamps
  always_comb begin
    if (window_length == '0) begin
      w = LEN_W'(1);
    end else if (32'(window_length) > WMAX) begin
      w = LEN_W'(WMAX);
    end else begin
      w = window_length;
    end
    if (average_length == '0) begin
      na = LEN_W'(1);
    end else if (average_length > w) begin
      na = w;
    end else begin
      na = average_length;
    end
    if (integrator_length == '0) begin
      ni = LEN_W'(1);
    end else if (integrator_length > w) begin
      ni = w;
    end else begin
      ni = integrator_length;
    end
  end

  // ring positions with wrap against the window in use
  always_comb begin
    s_cur       = (32'(sample_pos) >= 32'(w)) ? '0 : sample_pos;
    s_wrap      = (32'(s_cur) + 1 >= 32'(w));
    s_pos_next  = s_wrap ? '0 : s_cur + PW'(1);
    filled_next = ring_filled || s_wrap;
    d_cur       = (32'(deviation_pos) >= 32'(w)) ? '0 : deviation_pos;
    d_pos_next  = (32'(d_cur) + 1 >= 32'(w)) ? '0 : d_cur + PW'(1);
    dec_idx     = (idx == '0) ? PW'(w - LEN_W'(1)) : idx - PW'(1);
  end

  // handshake
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // walk control shared by the average and the deviation sum
  always_comb begin
    walk_len  = (state == ST_SUM) ? ni : na;
    issue     = ((state == ST_AVG) || (state == ST_SUM)) && (cnt < walk_len);
    walk_done = (cnt == walk_len) && !rd_pend;
  end

  // divider request: magnitude of the sample sum over the averaging length
  always_comb begin
    acc_mag          = acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
    div_req.start    = (state == ST_AVG) && walk_done;
    div_req.dividend = acc_mag;
    div_req.divisor  = na;
    q_ext            = DIFF_W'(div_rsp.quotient);
  end

  // deviation squared, saturating sum, smoother and level
  always_comb begin
    diff       = DIFF_W'(s_reg) - avg;
    mag        = diff[DIFF_W-1] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    sq         = mag * mag;
    sum_add    = {1'b0, sum} + (SUM_W+1)'(d_rdata);
    smooth_add = {1'b0, sum} + {1'b0, smoothed_sum};
    smooth_new = smooth_add[SUM_W:1];
    lvl        = smoothing_enable ? smooth_new : sum;
    if (threshold_enable && (lvl < SUM_W'(threshold))) begin
      lvl = '0;
    end
  end

  // deviation ring write: clearing pass or new squared deviation
  always_comb begin
    d_we    = (state == ST_CLEAR) || (state == ST_DEV);
    d_waddr = (state == ST_CLEAR) ? clr_idx : d_cur;
    d_wdata = (state == ST_CLEAR) ? '0 : sq;
  end

  rmvd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_sample_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (s_cur),
    .wdata (sample),
    .raddr (idx),
    .rdata (s_rdata)
  );

  rmvd_ram #(
    .WIDTH (DEV_W),
    .DEPTH (MAX_WINDOW)
  ) u_deviation_ring (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (idx),
    .rdata (d_rdata)
  );

  rmvd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= LEN_W'(256);
      average_length    <= LEN_W'(256);
      integrator_length <= LEN_W'(3);
      threshold         <= THR_W'(3);
      smoothing_enable  <= 1'b0;
      threshold_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:     window_length     <= cfg_data[LEN_W-1:0];
        REG_AVERAGE_LENGTH:    average_length    <= cfg_data[LEN_W-1:0];
        REG_INTEGRATOR_LENGTH: integrator_length <= cfg_data[LEN_W-1:0];
        REG_THRESHOLD:         threshold         <= cfg_data;
        REG_SMOOTHING_ENABLE:  smoothing_enable  <= cfg_data[0];
        REG_THRESHOLD_ENABLE:  threshold_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == PW'(MAX_WINDOW - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc) state_next = filled_next ? ST_AVG : ST_DONE;
      ST_AVG:   if (walk_done) state_next = ST_DIV;
      ST_DIV:   if (div_rsp.done) state_next = ST_DEV;
      ST_DEV:   state_next = ST_SUM;
      ST_SUM:   if (walk_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // output valid: set when a result loads, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx       <= '0;
      sample_pos    <= '0;
      ring_filled   <= 1'b0;
      deviation_pos <= '0;
      smoothed_sum  <= '0;
      rd_pend       <= 1'b0;
    end else begin
      case (state)
        // sweep zeros through the deviation ring
        ST_CLEAR: clr_idx <= clr_idx + PW'(1);
        // take the item, store the sample, start the average walk once the ring is full
        ST_IDLE: begin
          if (in_acc) begin
            s_reg       <= sample;
            sample_pos  <= s_pos_next;
            ring_filled <= filled_next;
            filling     <= !filled_next;
            idx         <= s_cur;
            cnt         <= '0;
            acc         <= '0;
            rd_pend     <= 1'b0;
          end
        end
        // walk back over the latest samples
        ST_AVG: begin
          if (issue) begin
            idx <= dec_idx;
            cnt <= cnt + LEN_W'(1);
          end
          rd_pend <= issue;
          if (rd_pend) begin
            acc <= acc + ACC_W'(signed'(s_rdata));
          end
        end
        // signed average, truncated toward zero
        ST_DIV: begin
          if (div_rsp.done) begin
            avg <= acc[ACC_W-1] ? -q_ext : q_ext;
          end
        end
        // squared deviation is written this cycle, start the sum walk
        ST_DEV: begin
          deviation_pos <= d_pos_next;
          idx           <= d_cur;
          cnt           <= '0;
          sum           <= '0;
          rd_pend       <= 1'b0;
        end
        // walk back over the latest deviations, saturating
        ST_SUM: begin
          if (issue) begin
            idx <= dec_idx;
            cnt <= cnt + LEN_W'(1);
          end
          rd_pend <= issue;
          if (rd_pend) begin
            sum <= (sum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
          end
        end
        // load the output register once it is free
        ST_DONE: begin
          if (out_free) begin
            if (filling) begin
              level <= '1;
            end else begin
              smoothed_sum <= smooth_new;
              level        <= LEVEL_W'(lvl);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
